@@ rtl/hcvc_pkg.sv @@
// Shared types, widths and helpers for the hex cell vertex connectivity core.
// No dependencies; every other RTL file imports this package.
package hcvc_pkg;

    localparam int AXIS_MAX = 1024;

    localparam int CNT_W   = 11;   // cell count register width
    localparam int IDX_W   = 30;   // linear cell index width
    localparam int POS_W   = 10;   // cell position width
    localparam int VTX_W   = 31;   // vertex index width
    localparam int PLANE_W = 21;   // cells in one z plane, up to 2^20
    localparam int REM_W   = 21;   // partial remainder inside the divider chain
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int QBITS   = 10;   // quotient bits per division
    localparam int NUM_STEPS = 2 * QBITS;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_CELLS_X = 2'd0;
    localparam logic [1:0] REG_CELLS_Y = 2'd1;
    localparam logic [1:0] REG_CELLS_Z = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] cells_x;
        logic [CNT_W-1:0] cells_y;
        logic [CNT_W-1:0] cells_z;
    } t_cfg;

    // Division state handed from one divider step to the next.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] dsr;
        logic [QBITS-1:0] low;    // dividend bits still to be shifted in
        logic [QBITS-1:0] quo;
    } t_div;

    // Control and side data that travel alongside the division.
    typedef struct packed {
        logic             valid;
        logic             err;
        logic [CNT_W-1:0] nx;
        logic [CNT_W-1:0] ny;
        logic [POS_W-1:0] k;
    } t_side;

    // A count of zero acts as one, and counts above AXIS_MAX saturate.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r);
        logic [CNT_W-1:0] v;
        if (r == '0) begin
            v = CNT_W'(1);
        end else if (r > CNT_W'(AXIS_MAX)) begin
            v = CNT_W'(AXIS_MAX);
        end else begin
            v = r;
        end
        return v;
    endfunction

endpackage

@@ rtl/hcvc_cfg.sv @@
// Configuration registers behind an APB-style port.
// Depends on hcvc_pkg for widths and register indexes.
module hcvc_cfg
    import hcvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_x <= CNT_W'(1);
            r_cfg.cells_y <= CNT_W'(1);
            r_cfg.cells_z <= CNT_W'(1);
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_CELLS_X: r_cfg.cells_x <= pwdata[CNT_W-1:0];
                REG_CELLS_Y: r_cfg.cells_y <= pwdata[CNT_W-1:0];
                REG_CELLS_Z: r_cfg.cells_z <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_CELLS_X: prdata = DATA_W'(r_cfg.cells_x);
            REG_CELLS_Y: prdata = DATA_W'(r_cfg.cells_y);
            REG_CELLS_Z: prdata = DATA_W'(r_cfg.cells_z);
            default:     prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/hcvc_front.sv @@
// Input skid stage, plane and total cell count products, and range check.
// Depends on hcvc_pkg; feeds the first divider step.
module hcvc_front
    import hcvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [IDX_W-1:0] i_cell_index,
    output t_div             o_div,
    output t_side            o_side
);

    logic             r_skid_full;
    logic [IDX_W-1:0] r_skid_idx;
    logic             w_accept;

    logic             r_s0_valid, r_s1_valid, r_s2_valid;
    logic [IDX_W-1:0] r_s0_idx, r_s1_idx, r_s2_idx;
    logic [CNT_W-1:0] r_s0_nx, r_s0_ny, r_s0_nz;
    logic [CNT_W-1:0] r_s1_nx, r_s1_ny, r_s1_nz;
    logic [CNT_W-1:0] r_s2_nx, r_s2_ny;
    logic [PLANE_W-1:0] r_s1_plane, r_s2_plane;
    logic [VTX_W-1:0] r_s2_total;
    logic [2*CNT_W-1:0] w_plane_full;
    logic [PLANE_W+CNT_W-1:0] w_total_full;

    t_div  r_div, n_div;
    t_side r_side, n_side;

    assign w_accept = i_valid && !r_skid_full;
    assign o_stall  = r_skid_full;

    assign w_plane_full = r_s0_nx * r_s0_ny;
    assign w_total_full = r_s1_plane * r_s1_nz;

    always_comb begin
        n_div.rem  = REM_W'(r_s2_idx[IDX_W-1:QBITS]);
        n_div.dsr  = r_s2_plane;
        n_div.low  = r_s2_idx[QBITS-1:0];
        n_div.quo  = '0;
        n_side.valid = r_s2_valid;
        n_side.err   = {1'b0, r_s2_idx} >= r_s2_total;
        n_side.nx    = r_s2_nx;
        n_side.ny    = r_s2_ny;
        n_side.k     = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_full  <= 1'b0;
            r_s0_valid   <= 1'b0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_skid_full <= 1'b0;
            r_s0_valid  <= r_skid_full || w_accept;
            r_s1_valid  <= r_s0_valid;
            r_s2_valid  <= r_s1_valid;
            r_side      <= n_side;
        end else if (w_accept) begin
            r_skid_full <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_en && w_accept) begin
            r_skid_idx <= i_cell_index;
        end
        if (i_en) begin
            r_s0_idx   <= r_skid_full ? r_skid_idx : i_cell_index;
            r_s0_nx    <= eff_count(i_cfg.cells_x);
            r_s0_ny    <= eff_count(i_cfg.cells_y);
            r_s0_nz    <= eff_count(i_cfg.cells_z);
            r_s1_idx   <= r_s0_idx;
            r_s1_nx    <= r_s0_nx;
            r_s1_ny    <= r_s0_ny;
            r_s1_nz    <= r_s0_nz;
            r_s1_plane <= w_plane_full[PLANE_W-1:0];
            r_s2_idx   <= r_s1_idx;
            r_s2_nx    <= r_s1_nx;
            r_s2_ny    <= r_s1_ny;
            r_s2_plane <= r_s1_plane;
            r_s2_total <= w_total_full[VTX_W-1:0];
            r_div      <= n_div;
        end
    end

    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

@@ rtl/hcvc_div_cell.sv @@
// One restoring division step: shift in a dividend bit, compare, subtract.
// Depends on hcvc_pkg; instantiated as a chain in the top level.
module hcvc_div_cell
    import hcvc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_div  i_div,
    input  t_side i_side,
    output t_div  o_div,
    output t_side o_side
);

    t_div           r_div, n_div;
    t_side          r_side;
    logic [REM_W:0] w_trial;
    logic           w_ge;

    assign w_trial = {i_div.rem, i_div.low[QBITS-1]};
    assign w_ge    = w_trial >= {1'b0, i_div.dsr};

    always_comb begin
        n_div.dsr = i_div.dsr;
        n_div.low = {i_div.low[QBITS-2:0], 1'b0};
        n_div.quo = {i_div.quo[QBITS-2:0], w_ge};
        if (w_ge) begin
            n_div.rem = REM_W'(w_trial - {1'b0, i_div.dsr});
        end else begin
            n_div.rem = REM_W'(w_trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side.valid <= 1'b0;
        end else if (i_en) begin
            r_side <= i_side;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

@@ rtl/hcvc_vertex.sv @@
// Vertex index pipeline: base vertex from i, j, k, then the eight corners.
// Depends on hcvc_pkg; its last stage is the block's output register.
module hcvc_vertex
    import hcvc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  t_side            i_side,
    input  logic [POS_W-1:0] i_i,
    input  logic [POS_W-1:0] i_j,
    output logic             o_valid,
    output logic [POS_W-1:0] o_cell_i,
    output logic [POS_W-1:0] o_cell_j,
    output logic [POS_W-1:0] o_cell_k,
    output logic [VTX_W-1:0] o_corner_zero,
    output logic [VTX_W-1:0] o_corner_one,
    output logic [VTX_W-1:0] o_corner_two,
    output logic [VTX_W-1:0] o_corner_three,
    output logic [VTX_W-1:0] o_corner_four,
    output logic [VTX_W-1:0] o_corner_five,
    output logic [VTX_W-1:0] o_corner_six,
    output logic [VTX_W-1:0] o_corner_seven,
    output logic             o_index_error
);

    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic r1_err, r2_err, r3_err;
    logic [POS_W-1:0] r1_i, r1_j, r1_k, r2_i, r2_j, r2_k, r3_i, r3_j, r3_k;
    logic [CNT_W-1:0] r1_vx, r2_vx, r3_vx;
    logic [PLANE_W-1:0] r1_vxy, r1_jvx, r2_vxy, r2_ij, r3_vxy, r3_dyz;
    logic [VTX_W-1:0] r2_kvxy, r3_base;

    logic [CNT_W-1:0] w_vx, w_vy;
    logic [2*CNT_W-1:0] w_vxy_full;
    logic [POS_W+CNT_W-1:0] w_jvx_full;
    logic [POS_W+PLANE_W-1:0] w_kvxy_full;

    assign w_vx        = i_side.nx + CNT_W'(1);
    assign w_vy        = i_side.ny + CNT_W'(1);
    assign w_vxy_full  = w_vx * w_vy;
    assign w_jvx_full  = i_j * w_vx;
    assign w_kvxy_full = r1_k * r1_vxy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_side.valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_err  <= i_side.err;
            r1_i    <= i_i;
            r1_j    <= i_j;
            r1_k    <= i_side.k;
            r1_vx   <= w_vx;
            r1_vxy  <= w_vxy_full[PLANE_W-1:0];
            r1_jvx  <= w_jvx_full[PLANE_W-1:0];

            r2_err  <= r1_err;
            r2_i    <= r1_i;
            r2_j    <= r1_j;
            r2_k    <= r1_k;
            r2_vx   <= r1_vx;
            r2_vxy  <= r1_vxy;
            r2_kvxy <= w_kvxy_full[VTX_W-1:0];
            r2_ij   <= PLANE_W'(r1_jvx + PLANE_W'(r1_i));

            r3_err  <= r2_err;
            r3_i    <= r2_i;
            r3_j    <= r2_j;
            r3_k    <= r2_k;
            r3_vx   <= r2_vx;
            r3_vxy  <= r2_vxy;
            r3_base <= VTX_W'(r2_kvxy + VTX_W'(r2_ij));
            r3_dyz  <= PLANE_W'(r2_vxy + PLANE_W'(r2_vx));

            // An index out of range clears every cell and corner field of the word.
            if (r3_err) begin
                o_cell_i       <= '0;
                o_cell_j       <= '0;
                o_cell_k       <= '0;
                o_corner_zero  <= '0;
                o_corner_one   <= '0;
                o_corner_two   <= '0;
                o_corner_three <= '0;
                o_corner_four  <= '0;
                o_corner_five  <= '0;
                o_corner_six   <= '0;
                o_corner_seven <= '0;
            end else begin
                o_cell_i       <= r3_i;
                o_cell_j       <= r3_j;
                o_cell_k       <= r3_k;
                o_corner_zero  <= r3_base;
                o_corner_one   <= VTX_W'(r3_base + VTX_W'(r3_vxy));
                o_corner_two   <= VTX_W'(r3_base + VTX_W'(r3_vxy) + VTX_W'(1));
                o_corner_three <= VTX_W'(r3_base + VTX_W'(1));
                o_corner_four  <= VTX_W'(r3_base + VTX_W'(r3_vx));
                o_corner_five  <= VTX_W'(r3_base + VTX_W'(r3_dyz));
                o_corner_six   <= VTX_W'(r3_base + VTX_W'(r3_dyz) + VTX_W'(1));
                o_corner_seven <= VTX_W'(r3_base + VTX_W'(r3_vx) + VTX_W'(1));
            end
            o_index_error <= r3_err;
        end
    end

    assign o_valid = r4_valid;

endmodule

@@ rtl/hex_cell_vertex_connectivity_core.sv @@
// Top level of the hex cell vertex connectivity core.
// Depends on hcvc_pkg, hcvc_cfg, hcvc_front, hcvc_div_cell and hcvc_vertex.
//
//   Channel   Direction  Handshake          Payload
//   cfg       in         psel/penable/...   paddr[3:0], pwdata[31:0], prdata
//   cell in   in         i_valid / o_stall  i_cell_index[29:0]
//   vertex    out        o_valid / i_stall  o_cell_i/j/k, eight corners, error
//
// One word is taken per cycle while the output does not stall; each word passes through
// an entry stage, two multiply stages, a range check, twenty divider steps
// (ten for k, ten for j) and four vertex arithmetic stages.
// A stall on the output freezes the whole pipeline; the input side then
// holds one word in a skid register, so o_stall is a register.
// Reset is synchronous; it clears only the valid flags and the skid flag and sets the count registers to one.
module hex_cell_vertex_connectivity_core
    import hcvc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [IDX_W-1:0]  i_cell_index,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [POS_W-1:0]  o_cell_i,
    output logic [POS_W-1:0]  o_cell_j,
    output logic [POS_W-1:0]  o_cell_k,
    output logic [VTX_W-1:0]  o_corner_zero,
    output logic [VTX_W-1:0]  o_corner_one,
    output logic [VTX_W-1:0]  o_corner_two,
    output logic [VTX_W-1:0]  o_corner_three,
    output logic [VTX_W-1:0]  o_corner_four,
    output logic [VTX_W-1:0]  o_corner_five,
    output logic [VTX_W-1:0]  o_corner_six,
    output logic [VTX_W-1:0]  o_corner_seven,
    output logic              o_index_error
);

    t_cfg  w_cfg;
    logic  w_en;
    t_div  w_div  [0:NUM_STEPS];
    t_side w_side [0:NUM_STEPS];

    assign w_en = !(o_valid && i_stall);

    hcvc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hcvc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_cfg        (w_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cell_index (i_cell_index),
        .o_div        (w_div[0]),
        .o_side       (w_side[0])
    );

    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
        t_div  w_in_div;
        t_side w_in_side;

        if (g == QBITS) begin : g_hand
            // The k quotient is done; the remainder becomes the dividend for j.
            always_comb begin
                w_in_side     = w_side[g];
                w_in_side.k   = w_div[g].quo;
                w_in_div.rem  = REM_W'(w_div[g].rem[2*QBITS-1:QBITS]);
                w_in_div.low  = w_div[g].rem[QBITS-1:0];
                w_in_div.dsr  = REM_W'(w_side[g].nx);
                w_in_div.quo  = '0;
            end
        end else begin : g_pass
            assign w_in_div  = w_div[g];
            assign w_in_side = w_side[g];
        end

        hcvc_div_cell u_div_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_div   (w_in_div),
            .i_side  (w_in_side),
            .o_div   (w_div[g+1]),
            .o_side  (w_side[g+1])
        );
    end

    hcvc_vertex u_vertex (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_side         (w_side[NUM_STEPS]),
        .i_i            (w_div[NUM_STEPS].rem[POS_W-1:0]),
        .i_j            (w_div[NUM_STEPS].quo),
        .o_valid        (o_valid),
        .o_cell_i       (o_cell_i),
        .o_cell_j       (o_cell_j),
        .o_cell_k       (o_cell_k),
        .o_corner_zero  (o_corner_zero),
        .o_corner_one   (o_corner_one),
        .o_corner_two   (o_corner_two),
        .o_corner_three (o_corner_three),
        .o_corner_four  (o_corner_four),
        .o_corner_five  (o_corner_five),
        .o_corner_six   (o_corner_six),
        .o_corner_seven (o_corner_seven),
        .o_index_error  (o_index_error)
    );

endmodule

@@ rtl/hcvc_checker.sv @@
// Port-level checks for the hex cell vertex connectivity core, with its bind.
// Depends on hcvc_pkg and on the top level's port names.
module hcvc_checker
    import hcvc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input logic [POS_W-1:0] o_cell_i,
    input logic [POS_W-1:0] o_cell_j,
    input logic [POS_W-1:0] o_cell_k,
    input logic [VTX_W-1:0] o_corner_zero,
    input logic [VTX_W-1:0] o_corner_one,
    input logic [VTX_W-1:0] o_corner_two,
    input logic [VTX_W-1:0] o_corner_three,
    input logic             o_index_error
);

    // A stalled output word stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_corner_zero)
            && $stable(o_index_error) && $stable(o_cell_i))
        else $error("output word changed while stalled");

    // The input side only stalls after the output side held the pipeline.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_stall) |-> $past(o_valid && i_stall && i_valid))
        else $error("input stall without an output stall");

    // An out-of-range index yields zero cell and corner fields.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> o_cell_i == '0 && o_cell_j == '0
            && o_cell_k == '0 && o_corner_zero == '0 && o_corner_two == '0)
        else $error("error word carries nonzero fields");

    // Corners one step apart along x differ by one vertex.
    a_x_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_index_error |-> o_corner_three == o_corner_zero + VTX_W'(1)
            && o_corner_two == o_corner_one + VTX_W'(1))
        else $error("x neighbor corners inconsistent");

endmodule

bind hex_cell_vertex_connectivity_core hcvc_checker u_hcvc_checker (.*);

@@ tb/tb_hex_cell_vertex_connectivity_core.sv @@
// Self-checking testbench for hex_cell_vertex_connectivity_core: random cell words
// under random valid/stall gaps, checked against a behavioral model of the grid math.
// Depends on hcvc_pkg and the core RTL.
module tb_hex_cell_vertex_connectivity_core
    import hcvc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REG_SPARE = 2'd3;   // decoded slot with no register behind it
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_PER_GRID = 150;
    localparam longint unsigned INDEX_SPAN = 64'd1 << IDX_W;
    localparam logic [IDX_W-1:0] INDEX_MAX = '1;

    typedef struct packed {
        logic [POS_W-1:0]        cell_i;
        logic [POS_W-1:0]        cell_j;
        logic [POS_W-1:0]        cell_k;
        logic [7:0][VTX_W-1:0]   corner;
        logic                    index_error;
    } t_vertex_word;

    class vertex_scoreboard;
        logic [CNT_W-1:0] count_x;
        logic [CNT_W-1:0] count_y;
        logic [CNT_W-1:0] count_z;
        t_vertex_word     expected_words[$];
        int               checked;
        int               out_of_range;
        int               mismatches;

        function new();
            count_x = CNT_W'(1);
            count_y = CNT_W'(1);
            count_z = CNT_W'(1);
            checked = 0;
            out_of_range = 0;
            mismatches = 0;
        endfunction

        function void set_count(logic [1:0] reg_idx, logic [DATA_W-1:0] value);
            case (reg_idx)
                REG_CELLS_X: count_x = value[CNT_W-1:0];
                REG_CELLS_Y: count_y = value[CNT_W-1:0];
                REG_CELLS_Z: count_z = value[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function longint unsigned axis_cells(logic [CNT_W-1:0] r);
            if (r == 0) return 1;
            if (r > AXIS_MAX) return AXIS_MAX;
            return r;
        endfunction

        function longint unsigned cell_total();
            return axis_cells(count_x) * axis_cells(count_y) * axis_cells(count_z);
        endfunction

        function t_vertex_word locate(logic [IDX_W-1:0] idx);
            t_vertex_word w;
            longint unsigned nx, ny, plane, i, j, k, rem, vx, vy;
            nx = axis_cells(count_x);
            ny = axis_cells(count_y);
            w = '0;
            if (idx >= cell_total()) begin
                w.index_error = 1'b1;
                return w;
            end
            plane = nx * ny;
            k = idx / plane;
            rem = idx - k * plane;
            j = rem / nx;
            i = rem - j * nx;
            vx = nx + 1;
            vy = ny + 1;
            w.cell_i = i[POS_W-1:0];
            w.cell_j = j[POS_W-1:0];
            w.cell_k = k[POS_W-1:0];
            // Corner order: x offset is bit 1, y offset is bit 2, z offset is bit 0 xor bit 1.
            for (int c = 0; c < 8; c++) begin
                longint unsigned a, b, d;
                a = i + c[1];
                b = j + c[2];
                d = k + (c[0] ^ c[1]);
                w.corner[c] = VTX_W'(a + b * vx + d * vx * vy);
            end
            return w;
        endfunction

        function void note_cell(logic [IDX_W-1:0] idx);
            t_vertex_word w;
            w = locate(idx);
            if (w.index_error) out_of_range++;
            expected_words = {expected_words, w};
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_word(t_vertex_word got);
            t_vertex_word exp_w;
            if (expected_words.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected output word, expected none, actual %p", $time, got);
                return;
            end
            exp_w = expected_words.pop_front();
            checked++;
            compare_field("cell_i", exp_w.cell_i, got.cell_i);
            compare_field("cell_j", exp_w.cell_j, got.cell_j);
            compare_field("cell_k", exp_w.cell_k, got.cell_k);
            for (int c = 0; c < 8; c++)
                compare_field($sformatf("corner %0d", c), exp_w.corner[c], got.corner[c]);
            compare_field("index_error", exp_w.index_error, got.index_error);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic [IDX_W-1:0]  i_cell_index = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [POS_W-1:0]  o_cell_i, o_cell_j, o_cell_k;
    logic [VTX_W-1:0]  o_corner_zero, o_corner_one, o_corner_two, o_corner_three;
    logic [VTX_W-1:0]  o_corner_four, o_corner_five, o_corner_six, o_corner_seven;
    logic              o_index_error;

    vertex_scoreboard sb = new();
    int tx_quiet = 0;
    int rx_quiet = 0;
    int stall_hold = 0;
    int idle_cycles = 0;
    int n_grids = 0;

    hex_cell_vertex_connectivity_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_cell_index   (i_cell_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_cell_i       (o_cell_i),
        .o_cell_j       (o_cell_j),
        .o_cell_k       (o_cell_k),
        .o_corner_zero  (o_corner_zero),
        .o_corner_one   (o_corner_one),
        .o_corner_two   (o_corner_two),
        .o_corner_three (o_corner_three),
        .o_corner_four  (o_corner_four),
        .o_corner_five  (o_corner_five),
        .o_corner_six   (o_corner_six),
        .o_corner_seven (o_corner_seven),
        .o_index_error  (o_index_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle lengths: mostly none or short, a few long, with occasional quiet stretches.
    function automatic int pick_idle(ref int quiet);
        int r;
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            quiet = $urandom_range(20, 80);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CNT_W'($urandom_range(AXIS_MAX + 1, 2047));
            2: return CNT_W'(AXIS_MAX);
            3: return CNT_W'($urandom_range(1, AXIS_MAX));
            default: return CNT_W'($urandom_range(1, 24));
        endcase
    endfunction

    // Mostly in-grid indices, some hugging the grid end, some anywhere in the field.
    function automatic logic [IDX_W-1:0] pick_index(longint unsigned total);
        int r;
        longint c;
        r = $urandom_range(0, 99);
        if (r < 75) return IDX_W'($urandom_range(0, 32'(total - 1)));
        if (r < 85) begin
            c = longint'(total) - 2 + $urandom_range(0, 3);
            if (c < 0) c = 0;
            if (c > longint'(INDEX_MAX)) c = INDEX_MAX;
            return c[IDX_W-1:0];
        end
        return IDX_W'($urandom());
    endfunction

    // Output side: check every accepted word, then pick the stall for the next cycle.
    always @(posedge i_clk) begin
        t_vertex_word got;
        if (i_rst_n && o_valid && !i_stall) begin
            got.cell_i = o_cell_i;
            got.cell_j = o_cell_j;
            got.cell_k = o_cell_k;
            got.corner[0] = o_corner_zero;
            got.corner[1] = o_corner_one;
            got.corner[2] = o_corner_two;
            got.corner[3] = o_corner_three;
            got.corner[4] = o_corner_four;
            got.corner[5] = o_corner_five;
            got.corner[6] = o_corner_six;
            got.corner[7] = o_corner_seven;
            got.index_error = o_index_error;
            sb.check_word(got);
        end
        if (stall_hold == 0) stall_hold = pick_idle(rx_quiet);
        i_stall <= (stall_hold > 0);
        if (stall_hold > 0) stall_hold--;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d still outstanding",
                     $time, WATCHDOG_LIMIT, sb.expected_words.size());
            $display("** hex_cell_vertex_connectivity_core: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic push_cell(logic [IDX_W-1:0] idx);
        int gap;
        gap = pick_idle(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cell_index <= idx;
        do @(posedge i_clk); while (o_stall);
        sb.note_cell(idx);
    endtask

    // Let the pipeline empty so the counts may change safely.
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] reg_idx, logic [CNT_W-1:0] value);
        logic [DATA_W-1:0] data;
        data = $urandom();
        data[CNT_W-1:0] = value;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_count(reg_idx, data);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_grid(logic [CNT_W-1:0] cx, logic [CNT_W-1:0] cy, logic [CNT_W-1:0] cz);
        settle();
        write_reg(REG_CELLS_X, cx);
        write_reg(REG_CELLS_Y, cy);
        write_reg(REG_CELLS_Z, cz);
        n_grids++;
    endtask

    task automatic push_grid_edges();
        longint unsigned total;
        total = sb.cell_total();
        push_cell('0);
        push_cell(IDX_W'(total - 1));
        if (total < INDEX_SPAN) push_cell(IDX_W'(total));
    endtask

    task automatic push_random(int count);
        repeat (count) push_cell(pick_index(sb.cell_total()));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Counts out of reset give a single-cell grid.
        n_grids++;
        push_cell('0);
        push_cell(IDX_W'(1));
        push_cell(INDEX_MAX);
        push_cell(30'h2AAA_AAAA);
        push_cell(30'h1555_5555);

        // Largest grid: every index in the field is a valid cell.
        set_grid(CNT_W'(AXIS_MAX), CNT_W'(AXIS_MAX), CNT_W'(AXIS_MAX));
        push_grid_edges();
        push_cell(IDX_W'(1023));
        push_cell(IDX_W'(1024));
        push_cell(IDX_W'(1048575));
        push_cell(IDX_W'(1048576));
        push_cell(30'h2AAA_AAAA);
        push_cell(30'h1555_5555);
        push_random(RANDOM_PER_GRID);

        // A zero count acts as one, oversized counts saturate.
        set_grid('0, CNT_W'(2047), CNT_W'(AXIS_MAX + 1));
        push_grid_edges();
        push_random(RANDOM_PER_GRID);

        set_grid(CNT_W'(2047), '0, '0);
        write_reg(REG_SPARE, pick_count());
        push_grid_edges();
        push_random(RANDOM_PER_GRID);

        set_grid(CNT_W'(3), CNT_W'(5), CNT_W'(7));
        push_grid_edges();
        push_random(RANDOM_PER_GRID);

        set_grid(CNT_W'(1), CNT_W'(AXIS_MAX), CNT_W'(1));
        push_random(RANDOM_PER_GRID);

        repeat (4) begin
            set_grid(pick_count(), pick_count(), pick_count());
            push_random(RANDOM_PER_GRID);
        end

        settle();
        $display("Checked %0d output words over %0d grid shapes, %0d of them out of range.",
                 sb.checked, n_grids, sb.out_of_range);
        if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
            $display("** hex_cell_vertex_connectivity_core: PASSED **");
        end else begin
            $display("** hex_cell_vertex_connectivity_core: FAILED **");
        end
        $finish;
    end

endmodule
